[src/merge_insertion_sorter_assert.svh]
// assertion macros shared by the sorter
`ifndef MERGE_INSERTION_SORTER_ASSERT_SVH
`define MERGE_INSERTION_SORTER_ASSERT_SVH

// same-cycle implication
`define MIS_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("merge_insertion_sorter: same-cycle check failed");

// next-cycle implication
`define MIS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("merge_insertion_sorter: next-cycle check failed");

`endif

[src/mis_pkg.sv]
package mis_pkg;

  localparam int DATA_W = 32;
  localparam int CMP_W = 12;
  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     is_last;
    logic [CMP_W-1:0]         comparisons;
  } result_t;

  typedef enum logic [4:0] {
    S_LOAD, S_PAIR_A0, S_PAIR_A1, S_PAIR_A2, S_PAIR_CMP,
    S_SWAP_R0, S_SWAP_R1, S_SWAP_W0, S_SWAP_W1,
    S_INIT, S_GROUP, S_ITEM_P, S_ITEM_K1, S_ITEM_K2,
    S_SRCH, S_SRCH_C, S_SRCH_A, S_SRCH_D,
    S_SHIFT_R, S_SHIFT_W, S_SHIFT_INS, S_UPD_R, S_UPD_W,
    S_PERM_C, S_PERM_R, S_PERM_W, S_COPY_R, S_COPY_W,
    S_OUT_R, S_OUT_S, S_OUT_L, S_OUT_V
  } state_t;

  typedef enum logic [1:0] {
    A_WR_INDEX, A_WR_READ, A_WR_HOLD, A_WR_TMP
  } a_wsel_t;

  typedef struct packed {
    logic    store_we;
    logic    a_we;
    a_wsel_t a_wsel;
    logic    chain_we;
    logic    chain_shift;
    logic    pos_we;
    logic    tmp_we;
    logic    key_load;
    logic    hold_load;
    logic    cmp_clear;
    logic    cmp_bump;
    logic    out_load;
    logic    out_is_last;
  } cmd_t;

  typedef struct packed {
    logic key_less;
    logic key_greater;
  } status_t;

endpackage

[src/mis_ram.sv]
module mis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mis_ctrl.sv]
module mis_ctrl #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_last,
  output logic                          item_stall,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mis_pkg::cmd_t                 cmd,
  input  mis_pkg::status_t              status,
  output logic [$clog2(MAX_ITEMS)-1:0]  store_waddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  a_raddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  a_waddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  a_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]  chain_raddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  chain_waddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  chain_wdata,
  input  logic [$clog2(MAX_ITEMS)-1:0]  chain_rdata,
  output logic [$clog2(MAX_ITEMS)-1:0]  pos_raddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  pos_waddr,
  output logic [$clog2(MAX_ITEMS)+1:0]  pos_wdata,
  input  logic [$clog2(MAX_ITEMS)+1:0]  pos_rdata,
  output logic [$clog2(MAX_ITEMS)-1:0]  tmp_raddr,
  output logic [$clog2(MAX_ITEMS)-1:0]  tmp_waddr
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = IW + 1;
  localparam int LW = (IW > 1) ? $clog2(IW) : 1;
  localparam int JW = CW + 2;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  mis_pkg::state_t state, state_next;

  logic [CW-1:0] cnt, n, k, msize, h, t, size, lo, len;
  logic [LW-1:0] lvl;
  logic [IW-1:0] i, j;
  logic [JW-1:0] ja, jb;

  logic [CW-1:0] m, p, np, g, mg, q, half, mid, pend, n_after, rem, size_c;
  logic [CW-1:0] pair_a, pair_b, swap_a, swap_b, item_addr, srch_addr, perm_rd, perm_wr;
  logic [JW-1:0] size_j;
  logic          accept, pair_last, deeper, group_end, pos_flag;
  logic [CW-1:0] pos_val;

  assign accept    = item_valid && !item_stall;
  assign n_after   = cnt + ((cnt < MAX_CNT) ? CW'(1) : CW'(0));
  assign m         = n >> lvl;
  assign p         = m >> 1;
  assign np        = (m - CW'(1)) >> 1;
  assign g         = CW'(1) << lvl;
  assign mg        = m << lvl;
  assign q         = h + t - CW'(1);
  assign half      = len >> 1;
  assign mid       = lo + half;
  assign pend      = (q << 1) + CW'(2);
  assign pair_a    = ({i, 1'b1} << lvl) - CW'(1);
  assign pair_b    = pair_a + g;
  assign swap_a    = ({i, 1'b0} << lvl) + CW'(j);
  assign swap_b    = swap_a + g;
  assign item_addr = ((pend + CW'(1)) << lvl) - CW'(1);
  assign srch_addr = (CW'(chain_rdata) << lvl) + g - CW'(1);
  assign perm_rd   = (CW'(chain_rdata) << lvl) + CW'(j);
  assign perm_wr   = (k << lvl) + CW'(j);
  assign pair_last = (CW'(i) + CW'(1)) == p;
  assign deeper    = (p >> 1) != '0;
  assign group_end = CW'(j) == (g - CW'(1));
  assign pos_flag  = pos_rdata[CW];
  assign pos_val   = pos_rdata[CW-1:0];
  assign rem       = np - h;
  assign size_j    = jb - ja;
  assign size_c    = (size_j > JW'(rem)) ? rem : CW'(size_j);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mis_pkg::S_LOAD: begin
        if (accept && item_last) begin
          state_next = (n_after >= CW'(2)) ? mis_pkg::S_PAIR_A0 : mis_pkg::S_OUT_R;
        end
      end
      mis_pkg::S_PAIR_A0:  state_next = mis_pkg::S_PAIR_A1;
      mis_pkg::S_PAIR_A1:  state_next = mis_pkg::S_PAIR_A2;
      mis_pkg::S_PAIR_A2:  state_next = mis_pkg::S_PAIR_CMP;
      mis_pkg::S_PAIR_CMP: begin
        if (status.key_greater) begin
          state_next = mis_pkg::S_SWAP_R0;
        end else begin
          state_next = (pair_last && !deeper) ? mis_pkg::S_INIT : mis_pkg::S_PAIR_A0;
        end
      end
      mis_pkg::S_SWAP_R0:  state_next = mis_pkg::S_SWAP_R1;
      mis_pkg::S_SWAP_R1:  state_next = mis_pkg::S_SWAP_W0;
      mis_pkg::S_SWAP_W0:  state_next = mis_pkg::S_SWAP_W1;
      mis_pkg::S_SWAP_W1: begin
        if (!group_end) begin
          state_next = mis_pkg::S_SWAP_R0;
        end else begin
          state_next = (pair_last && !deeper) ? mis_pkg::S_INIT : mis_pkg::S_PAIR_A0;
        end
      end
      mis_pkg::S_INIT: begin
        if (k == m - CW'(1)) begin
          state_next = mis_pkg::S_GROUP;
        end
      end
      mis_pkg::S_GROUP:    state_next = (h >= np) ? mis_pkg::S_PERM_C : mis_pkg::S_ITEM_P;
      mis_pkg::S_ITEM_P:   state_next = mis_pkg::S_ITEM_K1;
      mis_pkg::S_ITEM_K1:  state_next = mis_pkg::S_ITEM_K2;
      mis_pkg::S_ITEM_K2:  state_next = mis_pkg::S_SRCH;
      mis_pkg::S_SRCH:     state_next = (len == '0) ? mis_pkg::S_SHIFT_R : mis_pkg::S_SRCH_C;
      mis_pkg::S_SRCH_C:   state_next = mis_pkg::S_SRCH_A;
      mis_pkg::S_SRCH_A:   state_next = mis_pkg::S_SRCH_D;
      mis_pkg::S_SRCH_D:   state_next = mis_pkg::S_SRCH;
      mis_pkg::S_SHIFT_R:  state_next = (k == lo) ? mis_pkg::S_SHIFT_INS : mis_pkg::S_SHIFT_W;
      mis_pkg::S_SHIFT_W:  state_next = mis_pkg::S_SHIFT_R;
      mis_pkg::S_SHIFT_INS: state_next = mis_pkg::S_UPD_R;
      mis_pkg::S_UPD_R: begin
        if (k != np) begin
          state_next = mis_pkg::S_UPD_W;
        end else begin
          state_next = (t == CW'(1)) ? mis_pkg::S_GROUP : mis_pkg::S_ITEM_P;
        end
      end
      mis_pkg::S_UPD_W:    state_next = mis_pkg::S_UPD_R;
      mis_pkg::S_PERM_C:   state_next = mis_pkg::S_PERM_R;
      mis_pkg::S_PERM_R:   state_next = mis_pkg::S_PERM_W;
      mis_pkg::S_PERM_W: begin
        if (!group_end) begin
          state_next = mis_pkg::S_PERM_R;
        end else begin
          state_next = (k == m - CW'(1)) ? mis_pkg::S_COPY_R : mis_pkg::S_PERM_C;
        end
      end
      mis_pkg::S_COPY_R:   state_next = mis_pkg::S_COPY_W;
      mis_pkg::S_COPY_W: begin
        if (k == mg - CW'(1)) begin
          state_next = (lvl == '0) ? mis_pkg::S_OUT_R : mis_pkg::S_INIT;
        end else begin
          state_next = mis_pkg::S_COPY_R;
        end
      end
      mis_pkg::S_OUT_R:    state_next = mis_pkg::S_OUT_S;
      mis_pkg::S_OUT_S:    state_next = mis_pkg::S_OUT_L;
      mis_pkg::S_OUT_L:    state_next = mis_pkg::S_OUT_V;
      mis_pkg::S_OUT_V: begin
        if (!result_stall) begin
          state_next = (k == n - CW'(1)) ? mis_pkg::S_LOAD : mis_pkg::S_OUT_R;
        end
      end
    endcase
  end

  // commands and addresses
  always_comb begin
    cmd          = '0;
    cmd.a_wsel   = mis_pkg::A_WR_INDEX;
    item_stall   = 1'b1;
    result_valid = 1'b0;
    store_waddr  = IW'(cnt);
    a_raddr      = '0;
    a_waddr      = '0;
    a_wdata      = IW'(cnt);
    chain_raddr  = '0;
    chain_waddr  = '0;
    chain_wdata  = '0;
    pos_raddr    = '0;
    pos_waddr    = '0;
    pos_wdata    = '0;
    tmp_raddr    = '0;
    tmp_waddr    = IW'(perm_wr);
    unique case (state)
      mis_pkg::S_LOAD: begin
        item_stall = 1'b0;
        a_waddr    = IW'(cnt);
        if (accept && cnt < MAX_CNT) begin
          cmd.store_we = 1'b1;
          cmd.a_we     = 1'b1;
        end
        cmd.cmp_clear = accept && item_last;
      end
      mis_pkg::S_PAIR_A0: a_raddr = IW'(pair_a);
      mis_pkg::S_PAIR_A1: a_raddr = IW'(pair_b);
      mis_pkg::S_PAIR_A2: cmd.key_load = 1'b1;
      mis_pkg::S_PAIR_CMP: cmd.cmp_bump = 1'b1;
      mis_pkg::S_SWAP_R0: a_raddr = IW'(swap_a);
      mis_pkg::S_SWAP_R1: begin
        a_raddr       = IW'(swap_b);
        cmd.hold_load = 1'b1;
      end
      mis_pkg::S_SWAP_W0: begin
        cmd.a_we   = 1'b1;
        cmd.a_wsel = mis_pkg::A_WR_READ;
        a_waddr    = IW'(swap_a);
      end
      mis_pkg::S_SWAP_W1: begin
        cmd.a_we   = 1'b1;
        cmd.a_wsel = mis_pkg::A_WR_HOLD;
        a_waddr    = IW'(swap_b);
      end
      mis_pkg::S_INIT: begin
        cmd.chain_we = k <= p;
        chain_waddr  = IW'(k);
        chain_wdata  = (k == '0) ? '0 : IW'((k << 1) - CW'(1));
        cmd.pos_we   = k < np;
        pos_waddr    = IW'(k);
        pos_wdata    = {(k + CW'(1)) >= p, k + CW'(2)};
      end
      mis_pkg::S_GROUP: ;
      mis_pkg::S_ITEM_P: begin
        pos_raddr = IW'(q);
        a_raddr   = IW'(item_addr);
      end
      mis_pkg::S_ITEM_K1: ;
      mis_pkg::S_ITEM_K2: cmd.key_load = 1'b1;
      mis_pkg::S_SRCH:    chain_raddr = IW'(mid);
      mis_pkg::S_SRCH_C:  a_raddr = IW'(srch_addr);
      mis_pkg::S_SRCH_A:  ;
      mis_pkg::S_SRCH_D:  cmd.cmp_bump = 1'b1;
      mis_pkg::S_SHIFT_R: chain_raddr = IW'(k - CW'(1));
      mis_pkg::S_SHIFT_W: begin
        cmd.chain_we    = 1'b1;
        cmd.chain_shift = 1'b1;
        chain_waddr     = IW'(k);
      end
      mis_pkg::S_SHIFT_INS: begin
        cmd.chain_we = 1'b1;
        chain_waddr  = IW'(lo);
        chain_wdata  = IW'(pend);
      end
      mis_pkg::S_UPD_R: pos_raddr = IW'(k);
      mis_pkg::S_UPD_W: begin
        cmd.pos_we = !pos_flag && (pos_val >= lo);
        pos_waddr  = IW'(k);
        pos_wdata  = {1'b0, pos_val + CW'(1)};
      end
      mis_pkg::S_PERM_C: chain_raddr = IW'(k);
      mis_pkg::S_PERM_R: begin
        chain_raddr = IW'(k);
        a_raddr     = IW'(perm_rd);
      end
      mis_pkg::S_PERM_W: begin
        chain_raddr = IW'(k);
        cmd.tmp_we  = 1'b1;
      end
      mis_pkg::S_COPY_R: tmp_raddr = IW'(k);
      mis_pkg::S_COPY_W: begin
        cmd.a_we   = 1'b1;
        cmd.a_wsel = mis_pkg::A_WR_TMP;
        a_waddr    = IW'(k);
      end
      mis_pkg::S_OUT_R: a_raddr = IW'(k);
      mis_pkg::S_OUT_S: ;
      mis_pkg::S_OUT_L: begin
        cmd.out_load    = 1'b1;
        cmd.out_is_last = k == n - CW'(1);
      end
      mis_pkg::S_OUT_V: result_valid = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mis_pkg::S_LOAD;
      cnt   <= '0;
      n     <= '0;
      lvl   <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      msize <= '0;
      h     <= '0;
      t     <= '0;
      size  <= '0;
      lo    <= '0;
      len   <= '0;
      ja    <= '0;
      jb    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        mis_pkg::S_LOAD: begin
          if (accept) begin
            if (item_last) begin
              n   <= n_after;
              cnt <= '0;
              lvl <= '0;
              i   <= '0;
              j   <= '0;
              k   <= '0;
            end else begin
              cnt <= n_after;
            end
          end
        end
        mis_pkg::S_PAIR_CMP, mis_pkg::S_SWAP_W1: begin
          if (state == mis_pkg::S_SWAP_W1 && !group_end) begin
            j <= j + IW'(1);
          end else if (state == mis_pkg::S_PAIR_CMP && status.key_greater) begin
            j <= '0;
          end else if (!pair_last) begin
            i <= i + IW'(1);
          end else if (deeper) begin
            lvl <= lvl + LW'(1);
            i   <= '0;
          end else begin
            k <= '0;
          end
        end
        mis_pkg::S_INIT: begin
          msize <= p + CW'(1);
          h     <= '0;
          ja    <= JW'(1);
          jb    <= JW'(3);
          k     <= k + CW'(1);
        end
        mis_pkg::S_GROUP: begin
          if (h >= np) begin
            k <= '0;
            j <= '0;
          end else begin
            size <= size_c;
            t    <= size_c;
            ja   <= jb;
            jb   <= jb + (ja << 1);
          end
        end
        mis_pkg::S_ITEM_K1: begin
          lo  <= '0;
          len <= pos_flag ? msize : pos_val;
        end
        mis_pkg::S_SRCH: k <= msize;
        mis_pkg::S_SRCH_D: begin
          if (status.key_less) begin
            len <= half;
          end else begin
            lo  <= mid + CW'(1);
            len <= len - half - CW'(1);
          end
        end
        mis_pkg::S_SHIFT_W: k <= k - CW'(1);
        mis_pkg::S_SHIFT_INS: begin
          msize <= msize + CW'(1);
          k     <= h;
        end
        mis_pkg::S_UPD_R: begin
          if (k == np) begin
            if (t == CW'(1)) begin
              h <= h + size;
            end else begin
              t <= t - CW'(1);
            end
          end
        end
        mis_pkg::S_UPD_W: k <= k + CW'(1);
        mis_pkg::S_PERM_W: begin
          if (!group_end) begin
            j <= j + IW'(1);
          end else begin
            j <= '0;
            k <= (k == m - CW'(1)) ? '0 : k + CW'(1);
          end
        end
        mis_pkg::S_COPY_W: begin
          if (k == mg - CW'(1)) begin
            k <= '0;
            if (lvl != '0) begin
              lvl <= lvl - LW'(1);
            end
          end else begin
            k <= k + CW'(1);
          end
        end
        mis_pkg::S_OUT_V: begin
          if (!result_stall) begin
            k <= k + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[src/mis_dp.sv]
module mis_dp #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mis_pkg::cmd_t                       cmd,
  output mis_pkg::status_t                    status,
  input  logic signed [mis_pkg::DATA_W-1:0]   item_value,
  input  logic [$clog2(MAX_ITEMS)-1:0]        store_waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        a_raddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        a_waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        a_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]        a_rdata,
  input  logic [$clog2(MAX_ITEMS)-1:0]        chain_raddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        chain_waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        chain_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]        chain_rdata,
  input  logic [$clog2(MAX_ITEMS)-1:0]        pos_raddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        pos_waddr,
  input  logic [$clog2(MAX_ITEMS)+1:0]        pos_wdata,
  output logic [$clog2(MAX_ITEMS)+1:0]        pos_rdata,
  input  logic [$clog2(MAX_ITEMS)-1:0]        tmp_raddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        tmp_waddr,
  output mis_pkg::result_t                    result
);

  localparam int IW = $clog2(MAX_ITEMS);

  logic [mis_pkg::DATA_W-1:0]        store_rdata;
  logic signed [mis_pkg::DATA_W-1:0] key;
  logic [IW-1:0]                     hold, a_wmux, chain_wmux, tmp_rdata;
  logic [mis_pkg::CMP_W-1:0]         cmp;

  always_comb begin
    unique case (cmd.a_wsel)
      mis_pkg::A_WR_INDEX: a_wmux = a_wdata;
      mis_pkg::A_WR_READ:  a_wmux = a_rdata;
      mis_pkg::A_WR_HOLD:  a_wmux = hold;
      mis_pkg::A_WR_TMP:   a_wmux = tmp_rdata;
    endcase
  end

  assign chain_wmux = cmd.chain_shift ? chain_rdata : chain_wdata;

  // element values, addressed through the order memory
  mis_ram #(.WIDTH(mis_pkg::DATA_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk(clk), .we(cmd.store_we), .waddr(store_waddr), .wdata(item_value),
    .raddr(a_rdata), .rdata(store_rdata)
  );

  mis_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_order (
    .clk(clk), .we(cmd.a_we), .waddr(a_waddr), .wdata(a_wmux),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  mis_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_chain (
    .clk(clk), .we(cmd.chain_we), .waddr(chain_waddr), .wdata(chain_wmux),
    .raddr(chain_raddr), .rdata(chain_rdata)
  );

  mis_ram #(.WIDTH(IW + 2), .DEPTH(MAX_ITEMS)) u_pos (
    .clk(clk), .we(cmd.pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  mis_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_tmp (
    .clk(clk), .we(cmd.tmp_we), .waddr(tmp_waddr), .wdata(a_rdata),
    .raddr(tmp_raddr), .rdata(tmp_rdata)
  );

  assign status.key_less    = key < $signed(store_rdata);
  assign status.key_greater = key > $signed(store_rdata);

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= $signed(store_rdata);
    end
    if (cmd.hold_load) begin
      hold <= a_rdata;
    end
    if (cmd.out_load) begin
      result.sorted_value <= $signed(store_rdata);
      result.is_last      <= cmd.out_is_last;
      result.comparisons  <= cmp;
    end
  end

  // saturating comparison counter
  always_ff @(posedge clk) begin
    if (rst || cmd.cmp_clear) begin
      cmp <= '0;
    end else if (cmd.cmp_bump && cmp != mis_pkg::CMP_MAX) begin
      cmp <= cmp + mis_pkg::CMP_W'(1);
    end
  end

endmodule

[src/merge_insertion_sorter.sv]
// load: one element per cycle; the transfer marked last starts the sort, or the drain for a one-element set
// sort: per pairing level a compare per pair and, where the pair is out of order, a swap of
//   each element of its group, then per insertion a binary search, chain shifts and bound
//   updates, all bounded by the single read port of each working memory
// drain: sorted elements go out one at a time, each held while result_stall is high
// rst (synchronous, active high) empties the set; memories keep their contents
module merge_insertion_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mis_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output mis_pkg::result_t result
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int PW = IW + 2;

  mis_pkg::cmd_t    cmd;
  mis_pkg::status_t status;

  // memory ports between sequencer and datapath
  logic [IW-1:0] store_waddr;
  logic [IW-1:0] a_raddr, a_waddr, a_wdata, a_rdata;
  logic [IW-1:0] chain_raddr, chain_waddr, chain_wdata, chain_rdata;
  logic [IW-1:0] pos_raddr, pos_waddr;
  logic [PW-1:0] pos_wdata, pos_rdata;
  logic [IW-1:0] tmp_raddr, tmp_waddr;

  // sequencer: loading, pairing levels, grouped binary insertion, drain
  mis_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_last(item.last), .item_stall(item_stall),
    .result_valid(result_valid), .result_stall(result_stall),
    .cmd(cmd), .status(status),
    .store_waddr(store_waddr),
    .a_raddr(a_raddr), .a_waddr(a_waddr), .a_wdata(a_wdata),
    .chain_raddr(chain_raddr), .chain_waddr(chain_waddr),
    .chain_wdata(chain_wdata), .chain_rdata(chain_rdata),
    .pos_raddr(pos_raddr), .pos_waddr(pos_waddr),
    .pos_wdata(pos_wdata), .pos_rdata(pos_rdata),
    .tmp_raddr(tmp_raddr), .tmp_waddr(tmp_waddr)
  );

  // datapath: element, order, chain, bound and scratch memories, key compare
  mis_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .status(status),
    .item_value(item.value),
    .store_waddr(store_waddr),
    .a_raddr(a_raddr), .a_waddr(a_waddr), .a_wdata(a_wdata), .a_rdata(a_rdata),
    .chain_raddr(chain_raddr), .chain_waddr(chain_waddr),
    .chain_wdata(chain_wdata), .chain_rdata(chain_rdata),
    .pos_raddr(pos_raddr), .pos_waddr(pos_waddr),
    .pos_wdata(pos_wdata), .pos_rdata(pos_rdata),
    .tmp_raddr(tmp_raddr), .tmp_waddr(tmp_waddr),
    .result(result)
  );

`include "merge_insertion_sorter_assert.svh"

  // loading and draining never overlap
  `MIS_ASSERT_SAME(a_no_load_while_result, clk, rst, result_valid, item_stall)
  // the closing transfer of a set ends loading: the sort, or the drain for a one-element set, follows
  `MIS_ASSERT_NEXT(a_sort_starts, clk, rst, item_valid && !item_stall && item.last, item_stall)
  // after the final sorted element the block loads again
  `MIS_ASSERT_NEXT(a_load_after_set, clk, rst, result_valid && !result_stall && result.is_last, !item_stall)

endmodule
